>>> hdl/intlex_pkg.sv
// ----------------------------------------------------------------------------
// intlex_pkg - integer literal lexer shared definitions
// character codes, radix and type codes, and the structs passed between the
// lexer's modules
// ----------------------------------------------------------------------------
package intlex_pkg;

  localparam int CH_W    = 21;
  localparam int VALUE_W = 64;

  // character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 21'h30;  // 0
  localparam logic [CH_W-1:0] CH_ONE   = 21'h31;  // 1
  localparam logic [CH_W-1:0] CH_NINE  = 21'h39;  // 9
  localparam logic [CH_W-1:0] CH_LO_A  = 21'h61;  // a
  localparam logic [CH_W-1:0] CH_LO_F  = 21'h66;  // f
  localparam logic [CH_W-1:0] CH_UP_A  = 21'h41;  // A
  localparam logic [CH_W-1:0] CH_UP_F  = 21'h46;  // F
  localparam logic [CH_W-1:0] CH_LO_X  = 21'h78;  // x
  localparam logic [CH_W-1:0] CH_UP_X  = 21'h58;  // X
  localparam logic [CH_W-1:0] CH_LO_B  = 21'h62;  // b
  localparam logic [CH_W-1:0] CH_UP_B  = 21'h42;  // B
  localparam logic [CH_W-1:0] CH_LO_L  = 21'h6C;  // l
  localparam logic [CH_W-1:0] CH_UP_L  = 21'h4C;  // L
  localparam logic [CH_W-1:0] CH_LO_U  = 21'h75;  // u
  localparam logic [CH_W-1:0] CH_UP_U  = 21'h55;  // U

  // radix codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  localparam logic [VALUE_W-1:0] VALUE_ONES = {VALUE_W{1'b1}};

  // what one character is
  typedef struct packed {
    logic       is_zero;
    logic       is_nonzero_dec;
    logic       is_hex_digit;
    logic [3:0] digit;
    logic       is_x;
    logic       is_b;
    logic       is_u;
    logic       is_l;
    logic       upper_l;
  } char_class_t;

  // one finished literal, length travels separately
  typedef struct packed {
    logic               matched;
    logic [1:0]         radix;
    logic [2:0]         type_kind;
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } result_t;

endpackage

>>> hdl/intlex_class.sv
// ----------------------------------------------------------------------------
// intlex_class - character classifier
// decodes one code point into digit value and suffix/prefix letter flags
// ----------------------------------------------------------------------------
module intlex_class (
  input  logic [intlex_pkg::CH_W-1:0] ch,
  output intlex_pkg::char_class_t     cls
);
  import intlex_pkg::*;

  logic is_dec;
  logic is_lo_hex;
  logic is_up_hex;

  always_comb begin
    is_dec    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_lo_hex = (ch >= CH_LO_A) && (ch <= CH_LO_F);
    is_up_hex = (ch >= CH_UP_A) && (ch <= CH_UP_F);

    cls.is_zero        = (ch == CH_ZERO);
    cls.is_nonzero_dec = (ch >= CH_ONE) && (ch <= CH_NINE);
    cls.is_hex_digit   = is_dec || is_lo_hex || is_up_hex;
    // letters a..f and A..F have low nibble 1..6
    cls.digit          = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);
    cls.is_x           = (ch == CH_LO_X) || (ch == CH_UP_X);
    cls.is_b           = (ch == CH_LO_B) || (ch == CH_UP_B);
    cls.is_u           = (ch == CH_LO_U) || (ch == CH_UP_U);
    cls.is_l           = (ch == CH_LO_L) || (ch == CH_UP_L);
    cls.upper_l        = (ch == CH_UP_L);
  end

endmodule

>>> hdl/intlex_mac.sv
// ----------------------------------------------------------------------------
// intlex_mac - constant-radix multiply-add
// acc * radix + digit by shifts, with carry out of 64 bits
// ----------------------------------------------------------------------------
module intlex_mac (
  input  logic [intlex_pkg::VALUE_W-1:0] acc,
  input  logic [1:0]                     base,
  input  logic [3:0]                     digit,
  output logic [intlex_pkg::VALUE_W-1:0] sum,
  output logic                           carry
);
  import intlex_pkg::*;

  localparam int WIDE_W = VALUE_W + 4;

  logic [WIDE_W-1:0] acc_wide;
  logic [WIDE_W-1:0] scaled;
  logic [WIDE_W-1:0] wide;

  always_comb begin
    acc_wide = {4'd0, acc};
    case (base)
      RADIX_DEC: scaled = (acc_wide << 3) + (acc_wide << 1);
      RADIX_OCT: scaled = acc_wide << 3;
      RADIX_HEX: scaled = acc_wide << 4;
      default:   scaled = acc_wide << 1;
    endcase
    wide  = scaled + {{(WIDE_W-4){1'b0}}, digit};
    sum   = wide[VALUE_W-1:0];
    carry = |wide[WIDE_W-1:VALUE_W];
  end

endmodule

>>> hdl/intlex_fsm.sv
// ----------------------------------------------------------------------------
// intlex_fsm - literal recognizer
// phase machine, value accumulator and suffix tracking, one character a step
// ----------------------------------------------------------------------------
module intlex_fsm #(
  parameter int LENGTH_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    eoi,
  input  intlex_pkg::char_class_t cls,
  output logic                    emit,
  output intlex_pkg::result_t     res,
  output logic [LENGTH_BITS-1:0]  res_length
);
  import intlex_pkg::*;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_ZERO    = 4'd1,
    PH_PREFIX  = 4'd2,
    PH_DIGITS  = 4'd3,
    PH_AFTER_U = 4'd4,
    PH_U_L1    = 4'd5,
    PH_L1      = 4'd6,
    PH_L2      = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  phase_t                 phase, phase_next;
  logic [VALUE_W-1:0]     acc, acc_next;
  logic [LENGTH_BITS-1:0] len, len_next;
  logic [1:0]             base, base_next;
  logic                   uns, uns_next;
  logic [1:0]             longc, longc_next;
  logic                   upper, upper_next;
  logic                   ovf, ovf_next;

  logic [VALUE_W-1:0] mac_sum;
  logic               mac_carry;
  logic               ok;
  logic               cnt;
  logic               do_acc;
  logic               run_digits;
  logic               dig_ok;
  logic               same_l;

  intlex_mac u_mac (
    .acc   (acc),
    .base  (base),
    .digit (cls.digit),
    .sum   (mac_sum),
    .carry (mac_carry)
  );

  always_comb begin
    case (base)
      RADIX_DEC: dig_ok = cls.is_hex_digit && (cls.digit < 4'd10);
      RADIX_OCT: dig_ok = cls.is_hex_digit && (cls.digit < 4'd8);
      RADIX_HEX: dig_ok = cls.is_hex_digit;
      default:   dig_ok = cls.is_hex_digit && (cls.digit < 4'd2);
    endcase
    same_l = cls.is_l && (cls.upper_l == upper);

    phase_next = phase;
    acc_next   = acc;
    len_next   = len;
    base_next  = base;
    uns_next   = uns;
    longc_next = longc;
    upper_next = upper;
    ovf_next   = ovf;
    emit       = 1'b0;
    ok         = 1'b0;
    cnt        = 1'b0;
    do_acc     = 1'b0;
    run_digits = 1'b0;

    if (eoi) begin
      emit = 1'b1;
      case (phase)
        PH_ZERO, PH_DIGITS, PH_AFTER_U, PH_U_L1, PH_L1, PH_L2, PH_DONE: ok = 1'b1;
        default: ok = 1'b0;
      endcase
    end else begin
      case (phase)
        PH_START: begin
          if (cls.is_zero) begin
            base_next  = RADIX_OCT;
            acc_next   = '0;
            cnt        = 1'b1;
            phase_next = PH_ZERO;
          end else if (cls.is_nonzero_dec) begin
            base_next  = RADIX_DEC;
            acc_next   = {{(VALUE_W-4){1'b0}}, cls.digit};
            cnt        = 1'b1;
            phase_next = PH_DIGITS;
          end else begin
            emit = 1'b1;
          end
        end
        PH_ZERO: begin
          if (cls.is_x) begin
            base_next  = RADIX_HEX;
            cnt        = 1'b1;
            phase_next = PH_PREFIX;
          end else if (cls.is_b) begin
            base_next  = RADIX_BIN;
            cnt        = 1'b1;
            phase_next = PH_PREFIX;
          end else begin
            run_digits = 1'b1;
          end
        end
        PH_DIGITS: run_digits = 1'b1;
        PH_PREFIX: begin
          if (dig_ok) begin
            do_acc     = 1'b1;
            phase_next = PH_DIGITS;
          end else begin
            emit = 1'b1;
          end
        end
        PH_AFTER_U: begin
          if (cls.is_l) begin
            longc_next = 2'd1;
            upper_next = cls.upper_l;
            cnt        = 1'b1;
            phase_next = PH_U_L1;
          end else begin
            emit = 1'b1;
            ok   = 1'b1;
          end
        end
        PH_U_L1: begin
          if (same_l) begin
            longc_next = 2'd2;
            cnt        = 1'b1;
            phase_next = PH_DONE;
          end else begin
            emit = 1'b1;
            ok   = 1'b1;
          end
        end
        PH_L1: begin
          if (same_l) begin
            longc_next = 2'd2;
            cnt        = 1'b1;
            phase_next = PH_L2;
          end else if (cls.is_u) begin
            uns_next   = 1'b1;
            cnt        = 1'b1;
            phase_next = PH_DONE;
          end else begin
            emit = 1'b1;
            ok   = 1'b1;
          end
        end
        PH_L2: begin
          if (cls.is_u) begin
            uns_next   = 1'b1;
            cnt        = 1'b1;
            phase_next = PH_DONE;
          end else begin
            emit = 1'b1;
            ok   = 1'b1;
          end
        end
        PH_DONE: begin
          emit = 1'b1;
          ok   = 1'b1;
        end
        default: emit = 1'b1;
      endcase

      // digit run shared by the lone zero and the digit phase
      if (run_digits) begin
        if (dig_ok) begin
          do_acc     = 1'b1;
          phase_next = PH_DIGITS;
        end else if (cls.is_u) begin
          uns_next   = 1'b1;
          cnt        = 1'b1;
          phase_next = PH_AFTER_U;
        end else if (cls.is_l) begin
          longc_next = 2'd1;
          upper_next = cls.upper_l;
          cnt        = 1'b1;
          phase_next = PH_L1;
        end else begin
          emit = 1'b1;
          ok   = 1'b1;
        end
      end
    end

    if (cnt || do_acc) begin
      len_next = (len == LEN_MAX) ? len : len + 1'b1;
    end
    if (do_acc && !ovf) begin
      if (mac_carry) begin
        acc_next = VALUE_ONES;
        ovf_next = 1'b1;
      end else begin
        acc_next = mac_sum;
      end
    end

    if (emit) begin
      phase_next = PH_START;
      acc_next   = '0;
      len_next   = '0;
      base_next  = RADIX_DEC;
      uns_next   = 1'b0;
      longc_next = 2'd0;
      upper_next = 1'b0;
      ovf_next   = 1'b0;
    end

    res.matched   = ok;
    res.radix     = ok ? base : 2'd0;
    res.type_kind = ok ? {longc, uns} : 3'd0;
    res.value     = ok ? (ovf ? VALUE_ONES : acc) : '0;
    res.overflow  = ok && ovf;
    res_length    = ok ? len : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      acc   <= '0;
      len   <= '0;
      base  <= RADIX_DEC;
      uns   <= 1'b0;
      longc <= 2'd0;
      upper <= 1'b0;
      ovf   <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      acc   <= acc_next;
      len   <= len_next;
      base  <= base_next;
      uns   <= uns_next;
      longc <= longc_next;
      upper <= upper_next;
      ovf   <= ovf_next;
    end
  end

endmodule

>>> hdl/integer_literal_lexer.sv
// ----------------------------------------------------------------------------
// integer_literal_lexer - C/C++ integer literal recognizer
// one character per transfer in, one result per literal out
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one code point per transfer in ch, or
//   end_of_input to close the stream. the character that ends a literal is
//   dropped and the next transfer starts a new literal.
//   output channel (out_valid/out_ready): one transfer per literal, carrying
//   matched, literal_length, radix, type_kind, literal_value and overflow. a
//   failed match comes out with every field zero.
//   a result is offered by the result register, which loads when the
//   character that ends the literal steps the lexer out of the input
//   register; a stalled result holds that step back.
//   throughput: one character per cycle while the result side is not
//   stalled; each character is decoded and folded into the accumulator
//   by a single shift-add between the input register and the result register.
//   reset clears the phase machine and both registers; the block accepts a
//   character in the first cycle after reset.
//   a stalled receiver holds the result; one more character can wait in the
//   input register, then in_ready stays low until the result is taken.
// ----------------------------------------------------------------------------
module integer_literal_lexer #(
  parameter int LENGTH_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  // character channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [intlex_pkg::CH_W-1:0]    ch,
  input  logic                           end_of_input,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           matched,
  output logic [LENGTH_BITS-1:0]         literal_length,
  output logic [1:0]                     radix,
  output logic [2:0]                     type_kind,
  output logic [intlex_pkg::VALUE_W-1:0] literal_value,
  output logic                           overflow
);
  import intlex_pkg::*;

  // input register
  logic            in_full;
  logic [CH_W-1:0] ch_q;
  logic            eoi_q;

  // step the lexer when the result register can take whatever comes out
  logic            step;
  logic            emit;
  char_class_t     cls;
  result_t         res;
  logic [LENGTH_BITS-1:0] res_length;

  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  intlex_class u_class (
    .ch  (ch_q),
    .cls (cls)
  );

  intlex_fsm #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .eoi        (eoi_q),
    .cls        (cls),
    .emit       (emit),
    .res        (res),
    .res_length (res_length)
  );

  // input stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  // input stage payload, loaded on every transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_q  <= ch;
      eoi_q <= end_of_input;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (step && emit) begin
      matched        <= res.matched;
      literal_length <= res_length;
      radix          <= res.radix;
      type_kind      <= res.type_kind;
      literal_value  <= res.value;
      overflow       <= res.overflow;
    end
  end

endmodule

>>> hdl/intlex_checker.sv
// ----------------------------------------------------------------------------
// intlex_props - port-level checks for the integer literal lexer
// watches the result channel and reset behavior, bound to the top level
// ----------------------------------------------------------------------------
module intlex_props #(
  parameter int LENGTH_BITS = 10
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           matched,
  input logic [LENGTH_BITS-1:0]         literal_length,
  input logic [1:0]                     radix,
  input logic [2:0]                     type_kind,
  input logic [intlex_pkg::VALUE_W-1:0] literal_value,
  input logic                           overflow
);
  import intlex_pkg::*;

  // no result offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(literal_value) &&
      $stable(matched) && $stable(literal_length))
    else $error("stalled result changed");

  // a failed match carries nothing
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> literal_length == '0 && radix == 2'd0 &&
      type_kind == 3'd0 && literal_value == '0 && !overflow)
    else $error("failed match with nonzero fields");

  // overflow saturates the value
  a_ovf_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> literal_value == VALUE_ONES && matched)
    else $error("overflow without saturated value");

  // a match consumed at least one character and type stays in range
  a_match_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> literal_length != '0 && type_kind <= 3'd5)
    else $error("bad length or type on match");

endmodule

bind integer_literal_lexer intlex_props #(
  .LENGTH_BITS (LENGTH_BITS)
) u_intlex_props (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .matched        (matched),
  .literal_length (literal_length),
  .radix          (radix),
  .type_kind      (type_kind),
  .literal_value  (literal_value),
  .overflow       (overflow)
);

>>> verif/intlex_checker.sv
// ----------------------------------------------------------------------------
// intlex_checker - result checker for the integer literal lexer
// runs its own copy of the literal recognizer on every character transfer,
// queues the literals that it expects and compares each result transfer with
// the oldest of them, field by field
// ----------------------------------------------------------------------------
module intlex_checker #(
  parameter int LENGTH_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [intlex_pkg::CH_W-1:0]    ch,
  input  logic                           end_of_input,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           matched,
  input  logic [LENGTH_BITS-1:0]         literal_length,
  input  logic [1:0]                     radix,
  input  logic [2:0]                     type_kind,
  input  logic [intlex_pkg::VALUE_W-1:0] literal_value,
  input  logic                           overflow,
  output int                             fail_count,
  output int                             open_count
);
  import intlex_pkg::*;

  typedef enum logic [3:0] {
    LX_IDLE, LX_LEAD_ZERO, LX_RADIX_MARK, LX_DIGITS,
    LX_SUF_U, LX_SUF_UL, LX_SUF_L, LX_SUF_LL, LX_SUF_FULL
  } lex_phase_t;

  typedef struct packed {
    logic                   matched;
    logic [LENGTH_BITS-1:0] lit_len;
    logic [1:0]             radix;
    logic [2:0]             kind;
    logic [VALUE_W-1:0]     value;
    logic                   ovf;
  } literal_t;

  localparam logic [LENGTH_BITS-1:0] LEN_SAT = '1;

  lex_phase_t             ph;
  logic [VALUE_W-1:0]     acc;
  logic [LENGTH_BITS-1:0] len_cnt;
  logic [1:0]             base;
  logic                   u_seen;
  logic [1:0]             long_cnt;
  logic                   long_upper;
  logic                   ovf;
  literal_t               expected_lits[$];
  literal_t               want;
  int                     errs = 0;

  assign fail_count = errs;

  task automatic clear_lexer();
    ph         = LX_IDLE;
    acc        = '0;
    len_cnt    = '0;
    base       = RADIX_DEC;
    u_seen     = 1'b0;
    long_cnt   = 2'd0;
    long_upper = 1'b0;
    ovf        = 1'b0;
  endtask

  // failed literals come out with every field zero
  task automatic close_literal(input logic ok);
    literal_t lit;
    lit = '0;
    if (ok) begin
      lit.matched = 1'b1;
      lit.lit_len = len_cnt;
      lit.radix   = base;
      lit.kind    = {long_cnt, u_seen};
      lit.value   = ovf ? VALUE_ONES : acc;
      lit.ovf     = ovf;
    end
    expected_lits.push_back(lit);
    clear_lexer();
  endtask

  task automatic bump_len();
    if (len_cnt != LEN_SAT) len_cnt = len_cnt + 1'b1;
  endtask

  // value of c as a digit of base b, -1 if it is none
  function automatic int digit_in_base(logic [CH_W-1:0] c, logic [1:0] b);
    int v;
    v = -1;
    if (c >= CH_ZERO && c <= CH_NINE) v = int'(c - CH_ZERO);
    else if (c >= CH_LO_A && c <= CH_LO_F) v = int'(c - CH_LO_A) + 10;
    else if (c >= CH_UP_A && c <= CH_UP_F) v = int'(c - CH_UP_A) + 10;
    case (b)
      RADIX_DEC: if (v >= 10) v = -1;
      RADIX_OCT: if (v >= 8) v = -1;
      RADIX_BIN: if (v >= 2) v = -1;
      default: ;
    endcase
    return v;
  endfunction

  // widened multiply-add, anything above 64 bits is an overflow
  task automatic add_digit(input int d);
    logic [VALUE_W+3:0] wide;
    bump_len();
    if (!ovf) begin
      case (base)
        RADIX_DEC: wide = {4'd0, acc} * 68'd10;
        RADIX_OCT: wide = {4'd0, acc} << 3;
        RADIX_HEX: wide = {4'd0, acc} << 4;
        default:   wide = {4'd0, acc} << 1;
      endcase
      wide = wide + {64'd0, d[3:0]};
      if (wide[VALUE_W+3:VALUE_W] != 4'd0) begin
        ovf = 1'b1;
        acc = VALUE_ONES;
      end else begin
        acc = wide[VALUE_W-1:0];
      end
    end
  endtask

  task automatic lex_char(input logic [CH_W-1:0] c, input logic eoi);
    int   d;
    logic is_u;
    logic is_l;
    logic up;
    is_u = (c == CH_LO_U) || (c == CH_UP_U);
    is_l = (c == CH_LO_L) || (c == CH_UP_L);
    up   = (c == CH_UP_L);
    if (eoi) begin
      close_literal(!(ph == LX_IDLE || ph == LX_RADIX_MARK));
    end else begin
      case (ph)
        LX_IDLE: begin
          if (c == CH_ZERO) begin
            base = RADIX_OCT;
            acc  = '0;
            bump_len();
            ph   = LX_LEAD_ZERO;
          end else if (c >= CH_ONE && c <= CH_NINE) begin
            base = RADIX_DEC;
            acc  = '0;
            add_digit(int'(c - CH_ZERO));
            ph   = LX_DIGITS;
          end else begin
            close_literal(1'b0);
          end
        end
        LX_LEAD_ZERO, LX_DIGITS: begin
          d = digit_in_base(c, base);
          if (ph == LX_LEAD_ZERO && (c == CH_LO_X || c == CH_UP_X)) begin
            base = RADIX_HEX;
            bump_len();
            ph   = LX_RADIX_MARK;
          end else if (ph == LX_LEAD_ZERO && (c == CH_LO_B || c == CH_UP_B)) begin
            base = RADIX_BIN;
            bump_len();
            ph   = LX_RADIX_MARK;
          end else if (d >= 0) begin
            add_digit(d);
            ph = LX_DIGITS;
          end else if (is_u) begin
            u_seen = 1'b1;
            bump_len();
            ph = LX_SUF_U;
          end else if (is_l) begin
            long_cnt   = 2'd1;
            long_upper = up;
            bump_len();
            ph = LX_SUF_L;
          end else begin
            close_literal(1'b1);
          end
        end
        LX_RADIX_MARK: begin
          d = digit_in_base(c, base);
          if (d >= 0) begin
            add_digit(d);
            ph = LX_DIGITS;
          end else begin
            close_literal(1'b0);
          end
        end
        LX_SUF_U: begin
          if (is_l) begin
            long_cnt   = 2'd1;
            long_upper = up;
            bump_len();
            ph = LX_SUF_UL;
          end else begin
            close_literal(1'b1);
          end
        end
        LX_SUF_UL: begin
          if (is_l && up == long_upper) begin
            long_cnt = 2'd2;
            bump_len();
            ph = LX_SUF_FULL;
          end else begin
            close_literal(1'b1);
          end
        end
        LX_SUF_L: begin
          if (is_l && up == long_upper) begin
            long_cnt = 2'd2;
            bump_len();
            ph = LX_SUF_LL;
          end else if (is_u) begin
            u_seen = 1'b1;
            bump_len();
            ph = LX_SUF_FULL;
          end else begin
            close_literal(1'b1);
          end
        end
        LX_SUF_LL: begin
          if (is_u) begin
            u_seen = 1'b1;
            bump_len();
            ph = LX_SUF_FULL;
          end else begin
            close_literal(1'b1);
          end
        end
        LX_SUF_FULL: close_literal(1'b1);
        default:     close_literal(1'b0);
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errs++;
    end
  endtask

  // result side first: a result leaving now was predicted by a character
  // accepted at an earlier edge, never by the character accepted at this same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_lexer();
      expected_lits.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lits.size() == 0) begin
          $error("result transfer with no literal outstanding");
          errs++;
        end else begin
          want = expected_lits.pop_front();
          check_field("matched", 64'(want.matched), 64'(matched));
          check_field("literal_length", 64'(want.lit_len), 64'(literal_length));
          check_field("radix", 64'(want.radix), 64'(radix));
          check_field("type_kind", 64'(want.kind), 64'(type_kind));
          check_field("literal_value", want.value, literal_value);
          check_field("overflow", 64'(want.ovf), 64'(overflow));
        end
      end
      if (in_valid && in_ready) lex_char(ch, end_of_input);
    end
    open_count <= expected_lits.size();
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the integer literal lexer
// feeds character streams (a few hand-picked edge cases, then random
// well-formed literals mixed with noise and broken prefixes) under random
// idling on both channels; the checker beside the block predicts and
// compares every result
// ----------------------------------------------------------------------------
module tb_top;
  import intlex_pkg::*;

  localparam int LENGTH_BITS    = 10;
  localparam int RANDOM_ITEMS   = 820;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  // a few characters the package does not name
  localparam logic [CH_W-1:0] CH_SPACE = 21'h20;
  localparam logic [CH_W-1:0] CH_DOT   = 21'h2E;
  localparam logic [CH_W-1:0] CH_LO_G  = 21'h67;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic [CH_W-1:0]        ch           = '0;
  logic                   end_of_input = 1'b0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic                   matched;
  logic [LENGTH_BITS-1:0] literal_length;
  logic [1:0]             radix;
  logic [2:0]             type_kind;
  logic [VALUE_W-1:0]     literal_value;
  logic                   overflow;
  int                     fail_count;
  int                     open_count;

  int chars_sent   = 0;
  int random_start = 0;
  int in_idle_pct  = 0;   // chance of a gap before each character
  int out_idle_pct = 0;   // chance of a stall on the result side
  int ready_hold   = 0;
  int ready_gap    = 0;
  int mode_cycles  = 0;
  int quiet_cycles = 0;

  integer_literal_lexer #(.LENGTH_BITS(LENGTH_BITS)) dut (.*);

  intlex_checker #(.LENGTH_BITS(LENGTH_BITS)) lit_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 7) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // any code point, all 21 bits random
  function automatic logic [CH_W-1:0] any_code();
    return CH_W'($urandom());
  endfunction

  // digit character for value v, hex letters in either case
  function automatic logic [CH_W-1:0] digit_char(int v, logic up);
    if (v < 10) return CH_ZERO + CH_W'(v);
    return (up ? CH_UP_A : CH_LO_A) + CH_W'(v - 10);
  endfunction

  // one character transfer; valid stays up across back-to-back transfers
  // and only drops when a gap is taken
  task automatic put_char(input logic [CH_W-1:0] c, input logic eoi);
    int gap;
    gap = pick_gap(in_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    ch           <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // digit run in base b; top_heavy leans on the largest digit so runs near
  // 64 bits land on both sides of the overflow boundary
  task automatic put_digits(input logic [1:0] b, input int n, input logic top_heavy);
    int i;
    int v;
    int max_d;
    case (b)
      RADIX_DEC: max_d = 9;
      RADIX_OCT: max_d = 7;
      RADIX_HEX: max_d = 15;
      default:   max_d = 1;
    endcase
    for (i = 0; i < n; i++) begin
      v = (top_heavy && $urandom_range(0, 3) != 0) ? max_d : int'($urandom_range(0, max_d));
      put_char(digit_char(v, 1'($urandom_range(0, 1))), 1'b0);
    end
  endtask

  // whatever follows a literal: end of input, noise, a character that looks
  // like it could go on (digit 9, another suffix letter, x, g, dot, space),
  // or plain ascii
  task automatic put_ending();
    int              pick;
    logic [CH_W-1:0] c;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      put_char(any_code(), 1'b1);
    end else if (pick < 6) begin
      put_char(any_code(), 1'b0);
    end else if (pick < 9) begin
      case ($urandom_range(0, 7))
        0:       c = digit_char(9, 1'b0);
        1:       c = CH_LO_U;
        2:       c = CH_UP_L;
        3:       c = CH_LO_L;
        4:       c = CH_UP_X;
        5:       c = CH_LO_G;
        6:       c = CH_DOT;
        default: c = CH_SPACE;
      endcase
      put_char(c, 1'b0);
    end else begin
      put_char(CH_W'($urandom_range(0, 127)), 1'b0);
    end
  endtask

  // one random literal: mostly well formed with random base, digit count
  // and suffix; the rest noise, bare end of input, or a prefix with no digit
  task automatic send_literal();
    int         pick;
    int         k;
    int         n;
    int         nl;
    int         i;
    logic [1:0] b;
    logic       heavy;
    logic       has_u;
    logic       u_first;
    logic       lup;
    logic       mixed;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      put_char(any_code(), 1'b0);
    end else if (pick < 12) begin
      if ($urandom_range(0, 2) == 0) begin
        put_char(any_code(), 1'b1);
      end else begin
        put_char(CH_ZERO, 1'b0);
        if ($urandom_range(0, 1)) put_char($urandom_range(0, 1) ? CH_UP_X : CH_LO_X, 1'b0);
        else put_char($urandom_range(0, 1) ? CH_UP_B : CH_LO_B, 1'b0);
        put_ending();
      end
    end else begin
      b = 2'($urandom_range(0, 3));
      k = $urandom_range(0, 9);
      if (k < 7) begin
        n = $urandom_range(1, 6);
      end else if (k < 9) begin
        case (b)
          RADIX_DEC: n = $urandom_range(18, 21);
          RADIX_OCT: n = $urandom_range(21, 24);
          RADIX_HEX: n = $urandom_range(15, 17);
          default:   n = $urandom_range(62, 66);
        endcase
      end else begin
        n = $urandom_range(1, 30);
      end
      heavy = (k >= 7) && (k < 9) && ($urandom_range(0, 1) != 0);
      case (b)
        RADIX_DEC: begin
          put_char(digit_char($urandom_range(1, 9), 1'b0), 1'b0);
          put_digits(b, n - 1, heavy);
        end
        RADIX_OCT: begin
          // n == 1 leaves the lone zero
          put_char(CH_ZERO, 1'b0);
          put_digits(b, n - 1, heavy);
        end
        RADIX_HEX: begin
          put_char(CH_ZERO, 1'b0);
          put_char($urandom_range(0, 1) ? CH_UP_X : CH_LO_X, 1'b0);
          put_digits(b, n, heavy);
        end
        default: begin
          put_char(CH_ZERO, 1'b0);
          put_char($urandom_range(0, 1) ? CH_UP_B : CH_LO_B, 1'b0);
          put_digits(b, n, heavy);
        end
      endcase
      // suffix: an optional u and zero to two l in either order, sometimes mixed case
      if ($urandom_range(0, 9) >= 3) begin
        has_u   = ($urandom_range(0, 2) != 0);
        nl      = $urandom_range(0, 2);
        u_first = 1'($urandom_range(0, 1));
        lup     = 1'($urandom_range(0, 1));
        mixed   = ($urandom_range(0, 4) == 0);
        if (has_u && u_first) put_char($urandom_range(0, 1) ? CH_UP_U : CH_LO_U, 1'b0);
        for (i = 0; i < nl; i++)
          put_char((lup ^ (mixed && i == 1)) ? CH_UP_L : CH_LO_L, 1'b0);
        if (has_u && !u_first) put_char($urandom_range(0, 1) ? CH_UP_U : CH_LO_U, 1'b0);
      end
      put_ending();
    end
  endtask

  // result side: random stalls; the stall rate is re-rolled on the mode counter,
  // a third of the time to no stalling at all
  always @(posedge clk) begin
    if (rst) begin
      out_ready    <= 1'b0;
      ready_hold   <= 0;
      mode_cycles  <= 0;
      out_idle_pct <= 0;
    end else begin
      mode_cycles <= mode_cycles + 1;
      if (mode_cycles % 64 == 63)
        out_idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(5, 60));
      if (ready_hold > 0) begin
        out_ready  <= 1'b0;
        ready_hold <= ready_hold - 1;
      end else begin
        ready_gap = pick_gap(out_idle_pct);
        out_ready  <= (ready_gap == 0);
        ready_hold <= (ready_gap > 0) ? ready_gap - 1 : 0;
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    in_idle_pct = 25;

    // end of input before any character
    put_char(any_code(), 1'b1);
    // lowest and highest code points cannot start a literal
    put_char('0, 1'b0);
    put_char({CH_W{1'b1}}, 1'b0);
    // lone zero closed by end of input
    put_char(CH_ZERO, 1'b0);
    put_char(any_code(), 1'b1);
    // 9 after a leading zero ends the octal literal 0
    put_char(CH_ZERO, 1'b0);
    put_char(digit_char(9, 1'b0), 1'b0);
    // hex prefix with no digit before end of input
    put_char(CH_ZERO, 1'b0);
    put_char(CH_LO_X, 1'b0);
    put_char(any_code(), 1'b1);
    // binary prefix followed by a digit outside the base
    put_char(CH_ZERO, 1'b0);
    put_char(CH_UP_B, 1'b0);
    put_char(digit_char(2, 1'b0), 1'b0);
    // u then LL completes the suffix, so a further U ends it
    put_char(digit_char(7, 1'b0), 1'b0);
    put_char(CH_LO_U, 1'b0);
    put_char(CH_UP_L, 1'b0);
    put_char(CH_UP_L, 1'b0);
    put_char(CH_UP_U, 1'b0);
    // mixed lL is no double long: the L ends the literal
    put_char(digit_char(1, 1'b0), 1'b0);
    put_char(CH_LO_L, 1'b0);
    put_char(CH_UP_L, 1'b0);
    // L then u completes the suffix, x ends it
    put_char(digit_char(5, 1'b0), 1'b0);
    put_char(CH_UP_L, 1'b0);
    put_char(CH_LO_U, 1'b0);
    put_char(CH_LO_X, 1'b0);

    // random part, sender idling re-rolled now and then
    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0)
        in_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(5, 60));
      send_literal();
    end
    // close whatever literal may still be open
    put_char(any_code(), 1'b1);
    in_valid <= 1'b0;

    // open_count is registered, so let it catch up before polling it
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
